// ----- rtl/irpr_pkg.sv -----
package irpr_pkg;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_EDGE       = 3'd1,
    CMD_START_REC  = 3'd2,
    CMD_START_PLAY = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WRITE      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_REC  = 2'd2,
    MODE_PLAY = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_RECORD_PRESET = 1'b0,
    CFG_TIMEOUT_LIMIT = 1'b1
  } cfg_reg_t;

  localparam int          TIMER_W            = 16;
  localparam logic [15:0] RECORD_PRESET_RST  = 16'd10000;
  localparam logic [15:0] TIMEOUT_LIMIT_RST  = 16'd65000;

endpackage

// ----- rtl/irpr_store.sv -----
module irpr_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int W     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  output logic [W-1:0]  rdata_a,
  input  logic          ren_b,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [W-1:0]     rdata_q_a;
  logic [W-1:0]     rdata_q_b;
  logic             rvalid_a;
  logic             rvalid_b;

  // Write port. A read of the address being written returns the new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    if (ren_b) begin
      rdata_q_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
    end
  end

  // Entries that were never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_a <= 1'b0;
      rvalid_b <= 1'b0;
    end else begin
      if (clr) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid_a <= (we && waddr == raddr_a) || (!clr && valid[raddr_a]);
      if (ren_b) begin
        rvalid_b <= (we && waddr == raddr_b) || (!clr && valid[raddr_b]);
      end
    end
  end

  assign rdata_a = rvalid_a ? rdata_q_a : '0;
  assign rdata_b = rvalid_b ? rdata_q_b : '0;

  a_no_clr_with_write: assert property (@(posedge clk) disable iff (rst)
    !(clr && we))
    else $error("store clear and write in the same cycle");

  a_clr_invalidates: assert property (@(posedge clk) disable iff (rst)
    clr |=> !rvalid_a)
    else $error("read after clear returned a stale entry");

  a_write_bypass: assert property (@(posedge clk) disable iff (rst)
    (we && waddr == raddr_a) |=> (rvalid_a && rdata_q_a == $past(wdata)))
    else $error("read of the written address missed the new data");

endmodule

// ----- rtl/ir_pulse_record_replay_top.sv -----
// Infrared pulse recorder and replayer.
// Input channel (in_valid / in_stall) carries one command per transaction:
// tick, edge, start record, start play, read entry or write entry, with the
// entry index, value and count used by the read and write commands.
// Output channel (out_valid / out_stall) returns exactly one result per
// command: line level, activity, stored count, read data and a finish flag.
// A command is registered at acceptance and resolved when it advances from
// the input register into the output register, where its result raises
// out_valid; an output stall can hold it in the input register first. One
// command is accepted every cycle as long as the output side keeps up; the
// pulse store is a two-read, one-write memory whose current playback entry is
// prefetched at every edge, so no command waits on a memory read.
// Configuration (cfg_we, cfg_index, cfg_data) sets the record preset and the
// timeout limit; write it only while no transaction is in flight.
// Reset (rst, synchronous) empties the store, stops recording or replay and
// clears the internal line level (ir_level is not reset) and restores both
// configuration registers. When the receiver stalls, the output register
// holds its result, one further command is held in s1, then in_stall rises.
module ir_pulse_record_replay_top #(
  parameter int STORE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [6:0]  entry_index,
  input  logic [15:0] entry_value,
  input  logic [7:0]  entry_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ir_level,
  output logic [1:0]  activity,
  output logic [7:0]  pulse_count,
  output logic [15:0] read_value,
  output logic        finished
);

  import irpr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 1);

  logic [15:0] record_preset;
  logic [15:0] timeout_limit;

  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic [6:0]  s1_index;
  logic [15:0] s1_value;
  logic [7:0]  s1_total;

  logic        accept;
  logic        advance;

  logic [TIMER_W-1:0] timer, timer_next;
  logic [PW-1:0]      position, position_next;
  logic [PW-1:0]      count, count_next;
  mode_t              mode, mode_next;
  logic               level, level_next;
  logic [15:0]        entry_one, entry_one_next;

  logic               st_clr;
  logic               st_we;
  logic [AW-1:0]      st_waddr;
  logic [15:0]        st_wdata;
  logic [15:0]        cur_entry;
  logic [15:0]        idx_entry;
  logic [15:0]        rd_next;
  logic               fin_next;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_preset <= RECORD_PRESET_RST;
      timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RECORD_PRESET: record_preset <= cfg_data;
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_index <= entry_index;
      s1_value <= entry_value;
      s1_total <= entry_total;
    end
  end

  irpr_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .W     (16)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clr     (st_clr),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (AW'(position_next)),
    .rdata_a (cur_entry),
    .ren_b   (accept),
    .raddr_b (AW'(entry_index)),
    .rdata_b (idx_entry)
  );

  always_comb begin
    logic [TIMER_W-1:0] timer_inc;
    logic [PW-1:0]      pos_inc;
    logic               in_range;

    timer_inc = timer + 16'd1;
    pos_inc   = position + PW'(1);
    in_range  = 32'(s1_index) < 32'(STORE_DEPTH);

    timer_next     = timer;
    position_next  = position;
    count_next     = count;
    mode_next      = mode;
    level_next     = level;
    entry_one_next = entry_one;
    st_clr         = 1'b0;
    st_we          = 1'b0;
    st_waddr       = AW'(position);
    st_wdata       = timer;
    rd_next        = '0;
    fin_next       = 1'b0;

    if (advance) begin
      case (cmd_t'(s1_cmd))
        CMD_TICK: begin
          case (mode)
            MODE_WAIT: begin
              timer_next = record_preset;
            end
            MODE_REC: begin
              timer_next = timer_inc;
              if (timer_inc > timeout_limit) begin
                // Entry 1 still carries the preset held before the first edge.
                count_next     = position;
                st_we          = 1'b1;
                st_waddr       = AW'(1);
                st_wdata       = entry_one - record_preset;
                entry_one_next = entry_one - record_preset;
                mode_next      = MODE_IDLE;
                fin_next       = 1'b1;
              end
            end
            MODE_PLAY: begin
              timer_next = timer_inc;
              if (position >= count) begin
                level_next = 1'b0;
                mode_next  = MODE_IDLE;
                fin_next   = 1'b1;
              end else if (timer_inc >= cur_entry) begin
                level_next    = !level;
                position_next = pos_inc;
                timer_next    = '0;
                if (pos_inc >= count) begin
                  level_next = 1'b0;
                  mode_next  = MODE_IDLE;
                  fin_next   = 1'b1;
                end
              end
            end
            default: begin
              timer_next = timer_inc;
            end
          endcase
        end
        CMD_EDGE: begin
          if (mode == MODE_WAIT) begin
            st_we         = 1'b1;
            st_waddr      = '0;
            position_next = PW'(1);
            mode_next     = MODE_REC;
          end else if (mode == MODE_REC && position < PW'(STORE_DEPTH)) begin
            st_we         = 1'b1;
            position_next = pos_inc;
            timer_next    = '0;
            if (position == PW'(1)) begin
              entry_one_next = timer;
            end
          end
        end
        CMD_START_REC: begin
          st_clr         = 1'b1;
          position_next  = '0;
          count_next     = '0;
          timer_next     = record_preset;
          level_next     = 1'b0;
          entry_one_next = '0;
          mode_next      = MODE_WAIT;
        end
        CMD_START_PLAY: begin
          level_next    = 1'b0;
          position_next = '0;
          timer_next    = '0;
          mode_next     = MODE_PLAY;
          if (count == '0) begin
            mode_next = MODE_IDLE;
            fin_next  = 1'b1;
          end
        end
        CMD_READ: begin
          if (in_range) begin
            rd_next = idx_entry;
          end
        end
        CMD_WRITE: begin
          if (in_range) begin
            st_we    = 1'b1;
            st_waddr = AW'(s1_index);
            st_wdata = s1_value;
            if (s1_index == 7'd1) begin
              entry_one_next = s1_value;
            end
          end
          count_next = (32'(s1_total) > 32'(STORE_DEPTH)) ? PW'(STORE_DEPTH)
                                                          : PW'(s1_total);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer     <= '0;
      position  <= '0;
      count     <= '0;
      mode      <= MODE_IDLE;
      level     <= 1'b0;
      entry_one <= '0;
    end else begin
      timer     <= timer_next;
      position  <= position_next;
      count     <= count_next;
      mode      <= mode_next;
      level     <= level_next;
      entry_one <= entry_one_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ir_level    <= level_next;
      activity    <= mode_next;
      pulse_count <= 8'(count_next);
      read_value  <= rd_next;
      finished    <= fin_next;
    end
  end

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (activity == MODE_IDLE && !ir_level))
    else $error("finished transaction left the block active or the line high");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(STORE_DEPTH))
    else $error("stored count exceeds the store depth");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked output");

endmodule
